@@ hdl/flru_pkg.sv @@
// Shared constants and types for the fully associative LRU tag store.
`timescale 1ns / 1ps
`default_nettype none

package flru_pkg;

  // Store geometry and field widths.
  localparam int ENTRIES     = 16;
  localparam int ADDR_WIDTH  = 32;
  localparam int STAMP_WIDTH = 32;
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IN_ADDR_W   = 32;
  localparam int CNT_W       = 32;
  localparam int SLOT_W      = 4;

  // Search token that travels down the row of cells, one cell per cycle.
  typedef struct packed {
    logic                   valid;
    logic [ADDR_WIDTH-1:0]  addr;
    logic                   hit;
    logic [IDX_W-1:0]       hit_idx;
    logic                   have_best;
    logic [STAMP_WIDTH-1:0] best_stamp;
    logic [IDX_W-1:0]       best_idx;
  } tok_t;

  // Entry update broadcast to all cells once a search has finished.
  typedef struct packed {
    logic                   valid;
    logic                   install;
    logic [IDX_W-1:0]       idx;
    logic [ADDR_WIDTH-1:0]  tag;
    logic [STAMP_WIDTH-1:0] stamp;
  } upd_t;

endpackage

`default_nettype wire

@@ hdl/fully_assoc_lru_cache_tags.sv @@
// Top level: request control, counters and the row of tag cells.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_stall, in_address          | request in
//   out     | out_valid, out_stall, out_hit,          | result out
//           | out_hit_count, out_slot                 |
//
// A request's search token passes through the injection register and then the
// row of cells. The result is then registered along with the update for the
// chosen entry, and the output register is loaded from the held result. The
// next request is taken only once that result has moved to the output register.
// Reset is synchronous and clears all entries to invalid with stamp zero.
// A stalled result holds in the output register while the next request is
// taken; that request waits after its search until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module fully_assoc_lru_cache_tags import flru_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [IN_ADDR_W-1:0] in_address,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_hit,
  output logic [CNT_W-1:0]     out_hit_count,
  output logic [SLOT_W-1:0]    out_slot
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_HOLD   = 2'd2;

  localparam int SUM_W = (STAMP_WIDTH > CNT_W + 1) ? STAMP_WIDTH : CNT_W + 1;
  localparam logic [SUM_W-1:0] STAMP_MAX = SUM_W'({STAMP_WIDTH{1'b1}});
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  logic [1:0]             state_r;
  logic [1:0]             state_nxt;
  tok_t                   inj_r;
  tok_t                   inj_nxt;
  tok_t                   chain [0:ENTRIES];
  tok_t                   tail;
  upd_t                   upd_r;
  upd_t                   upd_nxt;
  logic [CNT_W-1:0]       access_count_r;
  logic [CNT_W-1:0]       hits_total_r;
  logic                   res_hit_r;
  logic [IDX_W-1:0]       res_slot_r;
  logic                   out_valid_r;
  logic                   out_hit_r;
  logic [CNT_W-1:0]       out_hit_count_r;
  logic [SLOT_W-1:0]      out_slot_r;
  logic                   in_take;
  logic                   out_free;
  logic                   search_done;
  logic [SUM_W-1:0]       stamp_sum;
  logic [STAMP_WIDTH-1:0] stamp_new;
  logic [IDX_W-1:0]       pick_idx;

  assign in_stall    = (state_r != ST_IDLE);
  assign in_take     = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign tail        = chain[ENTRIES];
  assign search_done = (state_r == ST_SEARCH) && tail.valid;

  // New stamp is the access number plus one, saturated to the stamp width.
  always_comb begin
    stamp_sum = SUM_W'(access_count_r) + SUM_W'(1);
    stamp_new = (stamp_sum > STAMP_MAX) ? STAMP_MAX[STAMP_WIDTH-1:0]
                                        : stamp_sum[STAMP_WIDTH-1:0];
    pick_idx  = tail.hit ? tail.hit_idx : tail.best_idx;
  end

  // Fresh token for an accepted request.
  always_comb begin
    inj_nxt       = '0;
    inj_nxt.valid = in_take;
    inj_nxt.addr  = ADDR_WIDTH'(in_address);
  end

  // Entry update for the chosen entry once the search has finished.
  always_comb begin
    upd_nxt       = upd_r;
    upd_nxt.valid = search_done;
    if (search_done) begin
      upd_nxt.install = !tail.hit;
      upd_nxt.idx     = pick_idx;
      upd_nxt.tag     = tail.addr;
      upd_nxt.stamp   = stamp_new;
    end
  end

  // Row of cells; the injection register feeds the first one.
  assign chain[0] = inj_r;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    flru_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .tok_i    (chain[i]),
      .upd_i    (upd_r),
      .tok_o    (chain[i+1])
    );
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tail.valid) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state, counters and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      inj_r          <= '0;
      upd_r          <= '0;
      access_count_r <= '0;
      hits_total_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Launch a fresh token on an accepted request.
      inj_r <= inj_nxt;

      // Finish the search: count, pick the entry and broadcast its update.
      upd_r <= upd_nxt;
      if (search_done) begin
        if (access_count_r != CNT_MAX) begin
          access_count_r <= access_count_r + CNT_W'(1);
        end
        if (tail.hit && (hits_total_r != CNT_MAX)) begin
          hits_total_r <= hits_total_r + CNT_W'(1);
        end
      end

      // Output register: loaded from the held result, cleared when taken.
      if ((state_r == ST_HOLD) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if ((state_r == ST_SEARCH) && tail.valid) begin
      res_hit_r  <= tail.hit;
      res_slot_r <= pick_idx;
    end
    if ((state_r == ST_HOLD) && out_free) begin
      out_hit_r       <= res_hit_r;
      out_hit_count_r <= hits_total_r;
      out_slot_r      <= SLOT_W'(res_slot_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_hit_count = out_hit_count_r;
  assign out_slot      = out_slot_r;

  // A token reaches the end of the row only while a search is running.
  a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> (state_r == ST_SEARCH))
    else $error("search token finished outside a search");

  // An entry update is only in flight while the result is held.
  a_upd_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    upd_r.valid |-> (state_r == ST_HOLD))
    else $error("entry update outside the hold state");

  // A result appears only after a hold.
  a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_HOLD))
    else $error("result loaded without a finished search");

  // The hit count never goes backward.
  a_hits_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (hits_total_r >= $past(hits_total_r)))
    else $error("hit count decreased");

endmodule

`default_nettype wire

@@ hdl/flru_cell.sv @@
// One tag store entry with its step of the match and least-stamp search.
`timescale 1ns / 1ps
`default_nettype none

module flru_cell import flru_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  tok_t             tok_i,
  input  upd_t             upd_i,
  output tok_t             tok_o
);

  logic [ADDR_WIDTH-1:0]  tag_r;
  logic                   valid_r;
  logic [STAMP_WIDTH-1:0] stamp_r;
  tok_t                   tok_r;
  tok_t                   tok_nxt;
  logic                   match;

  // Fold this entry into the token: first valid match wins, strict less keeps the lower index.
  always_comb begin
    tok_nxt = tok_i;
    match   = valid_r && (tag_r == tok_i.addr);
    if (!tok_i.hit && match) begin
      tok_nxt.hit     = 1'b1;
      tok_nxt.hit_idx = cell_idx;
    end
    if (!tok_i.have_best || (stamp_r < tok_i.best_stamp)) begin
      tok_nxt.have_best  = 1'b1;
      tok_nxt.best_stamp = stamp_r;
      tok_nxt.best_idx   = cell_idx;
    end
  end

  // Token hand-off and entry state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= '0;
      valid_r <= 1'b0;
      stamp_r <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (upd_i.valid && (upd_i.idx == cell_idx)) begin
        stamp_r <= upd_i.stamp;
        if (upd_i.install) begin
          valid_r <= 1'b1;
        end
      end
    end
  end

  // The tag is undefined until its first install.
  always_ff @(posedge clk) begin
    if (upd_i.valid && upd_i.install && (upd_i.idx == cell_idx)) begin
      tag_r <= upd_i.tag;
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

@@ dv/fully_assoc_lru_cache_tags_test.sv @@
// Self-checking testbench for the fully associative LRU tag store.
`timescale 1ns / 1ps

module fully_assoc_lru_cache_tags_test;
  import flru_pkg::*;

  localparam int RANDOM_LOOKUPS = 1230;
  localparam int MAX_WAIT       = 12;
  localparam int WORKING_MAX    = 24;
  localparam int DRAIN_CYCLES   = 4 * (ENTRIES + 3);

  typedef struct packed {
    logic              hit;
    logic [CNT_W-1:0]  hit_count;
    logic [SLOT_W-1:0] slot;
  } lookup_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [IN_ADDR_W-1:0] in_address = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_hit;
  logic [CNT_W-1:0]     out_hit_count;
  logic [SLOT_W-1:0]    out_slot;

  // Shadow copy of the tag store used to predict every lookup.
  logic [ADDR_WIDTH-1:0]  model_tag   [ENTRIES];
  logic                   model_valid [ENTRIES];
  logic [STAMP_WIDTH-1:0] model_stamp [ENTRIES];
  logic [CNT_W-1:0]       model_accesses;
  logic [CNT_W-1:0]       model_hits;

  logic [IN_ADDR_W-1:0] pending_addrs[$];
  lookup_result_t       expected_results[$];

  int mismatches = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit send_steady = 1'b0;
  bit recv_steady = 1'b0;

  fully_assoc_lru_cache_tags i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_address    (in_address),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_hit_count (out_hit_count),
    .out_slot      (out_slot)
  );

  // Look up one address in the shadow store and update it as the block would.
  function automatic lookup_result_t lru_lookup(input logic [IN_ADDR_W-1:0] address);
    logic [ADDR_WIDTH-1:0]  tag;
    logic [STAMP_WIDTH-1:0] oldest;
    logic [STAMP_WIDTH-1:0] new_stamp;
    logic [63:0]            next_stamp;
    int                     idx;
    bit                     found;
    lookup_result_t         res;
    tag = ADDR_WIDTH'(address);
    idx = 0;
    found = 1'b0;
    next_stamp = 64'(model_accesses) + 64'd1;
    if (STAMP_WIDTH < 64 && next_stamp > ((64'd1 << STAMP_WIDTH) - 64'd1)) begin
      next_stamp = (64'd1 << STAMP_WIDTH) - 64'd1;
    end
    new_stamp = STAMP_WIDTH'(next_stamp);
    for (int i = 0; i < ENTRIES; i++) begin
      if (!found && model_valid[i] && model_tag[i] == tag) begin
        found = 1'b1;
        idx = i;
      end
    end
    if (found) begin
      if (model_hits != '1) model_hits++;
    end else begin
      // Victim is the smallest stamp, lowest index on ties.
      oldest = model_stamp[0];
      for (int i = 1; i < ENTRIES; i++) begin
        if (model_stamp[i] < oldest) begin
          oldest = model_stamp[i];
          idx = i;
        end
      end
      model_valid[idx] = 1'b1;
      model_tag[idx] = tag;
    end
    model_stamp[idx] = new_stamp;
    if (model_accesses != '1) model_accesses++;
    res.hit = found;
    res.hit_count = model_hits;
    res.slot = SLOT_W'(idx);
    return res;
  endfunction

  function automatic int draw_wait(input bit steady);
    return steady ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  // Request driver: holds a stalled request, then waits its drawn gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) expected_results.push_back(lru_lookup(in_address));
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_addrs.size() != 0) begin
        in_valid <= 1'b1;
        in_address <= pending_addrs.pop_front();
        if ($urandom_range(0, 63) == 0) send_steady <= !send_steady;
        send_gap <= draw_wait(send_steady);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: checks each accepted result, then stalls for a drawn time.
  always @(posedge clk) begin : result_monitor
    int             wait_cycles;
    lookup_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap <= 0;
    end else begin
      wait_cycles = recv_gap;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result hit=%0b count=%0d slot=%0d",
                                    out_hit, out_hit_count, out_slot));
        end else begin
          want = expected_results.pop_front();
          if (out_hit !== want.hit)
            report_mismatch($sformatf("hit %0b, expected %0b", out_hit, want.hit));
          if (out_hit_count !== want.hit_count)
            report_mismatch($sformatf("hit_count %0d, expected %0d",
                                      out_hit_count, want.hit_count));
          if (out_slot !== want.slot)
            report_mismatch($sformatf("slot %0d, expected %0d", out_slot, want.slot));
        end
        if ($urandom_range(0, 63) == 0) recv_steady <= !recv_steady;
        wait_cycles = draw_wait(recv_steady);
      end
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        recv_gap <= wait_cycles - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [IN_ADDR_W-1:0] working_set [WORKING_MAX];
    int                   set_size;
    int                   pick;
    for (int i = 0; i < ENTRIES; i++) begin
      model_tag[i] = '0;
      model_valid[i] = 1'b0;
      model_stamp[i] = '0;
    end
    model_accesses = '0;
    model_hits = '0;
    set_size = 1;

    // Field extremes, a hit, then a full store and LRU evictions.
    pending_addrs.push_back(32'h0000_0000);
    pending_addrs.push_back(32'hFFFF_FFFF);
    pending_addrs.push_back(32'h0000_0000);
    pending_addrs.push_back(32'hAAAA_AAAA);
    pending_addrs.push_back(32'h5555_5555);
    pending_addrs.push_back(32'h8000_0000);
    pending_addrs.push_back(32'h0000_0001);
    for (int i = 0; i < 10; i++) pending_addrs.push_back(32'h0000_0010 + i);
    pending_addrs.push_back(32'hDEAD_BEEF);
    pending_addrs.push_back(32'hFFFF_FFFF);
    pending_addrs.push_back(32'h5555_5555);
    pending_addrs.push_back(32'hAAAA_AAAB);
    pending_addrs.push_back(32'h0000_0010);

    // Random lookups over changing working sets, with some unrelated addresses.
    for (int n = 0; n < RANDOM_LOOKUPS; n++) begin
      if (n % 200 == 0) begin
        set_size = $urandom_range(4, WORKING_MAX);
        for (int k = 0; k < WORKING_MAX; k++) begin
          working_set[k] = $urandom();
          // Near neighbors check that the whole tag is compared.
          if (k > 0 && $urandom_range(0, 3) == 0)
            working_set[k] = working_set[k - 1] ^ (32'd1 << $urandom_range(0, 31));
        end
      end
      pick = $urandom_range(0, 9);
      if (pick < 4)
        pending_addrs.push_back(working_set[$urandom_range(0, set_size / 3)]);
      else if (pick < 8)
        pending_addrs.push_back(working_set[$urandom_range(0, set_size - 1)]);
      else
        pending_addrs.push_back($urandom());
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_addrs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("fully_assoc_lru_cache_tags regression: pass");
    end else begin
      $display("fully_assoc_lru_cache_tags regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("fully_assoc_lru_cache_tags regression: fail");
    $finish;
  end

endmodule

@@ fully_assoc_lru_cache_tags.f @@
hdl/flru_pkg.sv
hdl/flru_cell.sv
hdl/fully_assoc_lru_cache_tags.sv
dv/fully_assoc_lru_cache_tags_test.sv
